// ===== hdl/ptrs_pkg.sv =====
// Package for the pose to TRS matrix unit: beat structs, widths, pipeline depth.
// Used by every module of the block; depends on nothing.
`timescale 1ns / 1ps
package ptrs_pkg;

  localparam int unsigned NUM_W      = 35;  // signed rotation numerator
  localparam int unsigned NRM_W      = 33;  // squared quaternion norm, up to 2^32
  localparam int unsigned DIV_STAGES = 32;  // one quotient bit per stage
  localparam int unsigned NUMER_LAT  = 2;   // product stage, numerator stage
  localparam int unsigned LANE_LAT   = DIV_STAGES + 3;
  localparam int unsigned LAT        = NUMER_LAT + LANE_LAT;

  typedef logic signed [NUM_W-1:0] num_t;
  typedef logic [NRM_W-1:0]        nrm_t;

  typedef struct packed {
    logic signed [31:0] trans_x;
    logic signed [31:0] trans_y;
    logic signed [31:0] trans_z;
    logic signed [15:0] quat_x;
    logic signed [15:0] quat_y;
    logic signed [15:0] quat_z;
    logic signed [15:0] quat_w;
    logic signed [31:0] scale_x;
    logic signed [31:0] scale_y;
    logic signed [31:0] scale_z;
  } in_beat_t;

  typedef struct packed {
    logic signed [31:0] col0_x;
    logic signed [31:0] col0_y;
    logic signed [31:0] col0_z;
    logic signed [31:0] col1_x;
    logic signed [31:0] col1_y;
    logic signed [31:0] col1_z;
    logic signed [31:0] col2_x;
    logic signed [31:0] col2_y;
    logic signed [31:0] col2_z;
    logic signed [31:0] out_tx;
    logic signed [31:0] out_ty;
    logic signed [31:0] out_tz;
  } out_beat_t;

endpackage

// ===== hdl/ptrs_numer.sv =====
// Quaternion products and rotation numerators, two register stages.
// Depends on ptrs_pkg.
`timescale 1ns / 1ps
module ptrs_numer (
  input  logic                       clk_i,
  input  logic                       en_i,
  input  logic signed [15:0]         qx_i,
  input  logic signed [15:0]         qy_i,
  input  logic signed [15:0]         qz_i,
  input  logic signed [15:0]         qw_i,
  output ptrs_pkg::num_t             num_o [9],
  output ptrs_pkg::nrm_t             nrm_o,
  output logic                       zero_o
);
  import ptrs_pkg::*;

  logic signed [31:0] xx_q, yy_q, zz_q, ww_q, xy_q, xz_q, yz_q, wx_q, wy_q, wz_q;
  num_t num_d [9];
  num_t num_q [9];
  num_t nn;
  nrm_t nrm_q;
  logic zero_q;

  function automatic num_t ext(input logic signed [31:0] a);
    ext = {{(NUM_W-32){a[31]}}, a};
  endfunction

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      xx_q <= qx_i * qx_i;
      yy_q <= qy_i * qy_i;
      zz_q <= qz_i * qz_i;
      ww_q <= qw_i * qw_i;
      xy_q <= qx_i * qy_i;
      xz_q <= qx_i * qz_i;
      yz_q <= qy_i * qz_i;
      wx_q <= qw_i * qx_i;
      wy_q <= qw_i * qy_i;
      wz_q <= qw_i * qz_i;
    end
  end

  always_comb begin
    nn       = ext(xx_q) + ext(yy_q) + ext(zz_q) + ext(ww_q);
    num_d[0] = nn - ((ext(yy_q) + ext(zz_q)) <<< 1);
    num_d[1] = (ext(xy_q) + ext(wz_q)) <<< 1;
    num_d[2] = (ext(xz_q) - ext(wy_q)) <<< 1;
    num_d[3] = (ext(xy_q) - ext(wz_q)) <<< 1;
    num_d[4] = nn - ((ext(xx_q) + ext(zz_q)) <<< 1);
    num_d[5] = (ext(yz_q) + ext(wx_q)) <<< 1;
    num_d[6] = (ext(xz_q) + ext(wy_q)) <<< 1;
    num_d[7] = (ext(yz_q) - ext(wx_q)) <<< 1;
    num_d[8] = nn - ((ext(xx_q) + ext(yy_q)) <<< 1);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      num_q  <= num_d;
      nrm_q  <= nn[NRM_W-1:0];
      zero_q <= (nn == '0);
    end
  end

  assign num_o  = num_q;
  assign nrm_o  = nrm_q;
  assign zero_o = zero_q;

endmodule

// ===== hdl/ptrs_lane.sv =====
// One matrix entry: scale multiply, rounding bias, bit-per-stage divider,
// sign and saturation. Depends on ptrs_pkg.
`timescale 1ns / 1ps
module ptrs_lane #(
  parameter bit DIAG = 1'b0
) (
  input  logic               clk_i,
  input  logic               en_i,
  input  ptrs_pkg::num_t     num_i,
  input  logic signed [31:0] s_i,
  input  ptrs_pkg::nrm_t     nrm_i,
  input  logic               zero_i,
  output logic signed [31:0] res_o
);
  import ptrs_pkg::*;

  num_t        un_full;
  logic [32:0] us_full;
  logic [63:0] mag_d, mag_q;
  logic        neg_q;
  nrm_t        nm_q;
  logic        zm_q;
  logic signed [31:0] sm_q;
  logic [63:0] dvd;

  logic [32:0]        rem_q [DIV_STAGES+1];
  logic [31:0]        low_q [DIV_STAGES+1];
  nrm_t               nd_q  [DIV_STAGES+1];
  logic               ng_q  [DIV_STAGES+1];
  logic               zr_q  [DIV_STAGES+1];
  logic signed [31:0] sd_q  [DIV_STAGES+1];

  logic [31:0]        quo;
  logic signed [31:0] res_d, res_q;

  always_comb begin
    un_full = num_i[NUM_W-1] ? -num_i : num_i;
    us_full = s_i[31] ? -{1'b1, s_i} : {1'b0, s_i};
    mag_d   = {31'b0, un_full[32:0]} * {32'b0, us_full[31:0]};
  end

  // Multiply stage
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      mag_q <= mag_d;
      neg_q <= num_i[NUM_W-1] ^ s_i[31];
      nm_q  <= nrm_i;
      zm_q  <= zero_i;
      sm_q  <= s_i;
    end
  end

  // Add half the divisor for round to nearest, ties away from zero
  assign dvd = mag_q + {{(64-NRM_W+1){1'b0}}, nm_q[NRM_W-1:1]};

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0] <= {1'b0, dvd[63:32]};
      low_q[0] <= dvd[31:0];
      nd_q[0]  <= nm_q;
      ng_q[0]  <= neg_q;
      zr_q[0]  <= zm_q;
      sd_q[0]  <= sm_q;
    end
  end

  for (genvar k = 0; k < DIV_STAGES; k++) begin : g_div
    logic [33:0] trial;
    logic [33:0] diff;
    logic        ge;
    assign trial = {rem_q[k], low_q[k][31]};
    assign diff  = trial - {1'b0, nd_q[k]};
    assign ge    = (trial >= {1'b0, nd_q[k]});
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k+1] <= ge ? diff[32:0] : trial[32:0];
        low_q[k+1] <= {low_q[k][30:0], ge};
        nd_q[k+1]  <= nd_q[k];
        ng_q[k+1]  <= ng_q[k];
        zr_q[k+1]  <= zr_q[k];
        sd_q[k+1]  <= sd_q[k];
      end
    end
  end

  assign quo = low_q[DIV_STAGES];

  always_comb begin
    if (zr_q[DIV_STAGES]) begin
      res_d = DIAG ? sd_q[DIV_STAGES] : '0;
    end else if (ng_q[DIV_STAGES]) begin
      res_d = (quo >= 32'h8000_0000) ? 32'sh8000_0000 : -$signed(quo);
    end else begin
      res_d = quo[31] ? 32'sh7fff_ffff : $signed(quo);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      res_q <= res_d;
    end
  end

  assign res_o = res_q;

endmodule

// ===== hdl/pose_to_trs_matrix_unit.sv =====
// Pose to TRS matrix: quaternion plus scale plus translation to affine columns.
// One beat per cycle unless a finished beat is stalled at the output.
// Divider lanes (one quotient bit per stage, nine in parallel) set the depth.
// Whole pipeline advances together; it holds while the output beat is stalled.
// Reset clears only the valid bits; payload registers are not reset.
`timescale 1ns / 1ps
module pose_to_trs_matrix_unit (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  ptrs_pkg::in_beat_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output ptrs_pkg::out_beat_t out_data_o
);
  import ptrs_pkg::*;

  // Valid bit for each pipeline stage; the last one is the output register.
  logic [LAT-1:0] vld_q, vld_d;
  logic           adv;

  // Translation rides alongside untouched.
  logic signed [31:0] tx_q [LAT];
  logic signed [31:0] ty_q [LAT];
  logic signed [31:0] tz_q [LAT];

  // Scales delayed to meet the numerators at the lane inputs.
  logic signed [31:0] sa_q [3];
  logic signed [31:0] sb_q [3];

  num_t               num [9];
  nrm_t               nrm;
  logic               zero;
  logic signed [31:0] res [9];

  // Advance unless a finished beat is waiting on a stalled consumer.
  assign adv        = !(vld_q[LAT-1] && out_stall_i);
  assign in_stall_o = !adv;

  assign vld_d = {vld_q[LAT-2:0], in_valid_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      tx_q[0] <= in_data_i.trans_x;
      ty_q[0] <= in_data_i.trans_y;
      tz_q[0] <= in_data_i.trans_z;
      for (int i = 1; i < LAT; i++) begin
        tx_q[i] <= tx_q[i-1];
        ty_q[i] <= ty_q[i-1];
        tz_q[i] <= tz_q[i-1];
      end
      sa_q[0] <= in_data_i.scale_x;
      sa_q[1] <= in_data_i.scale_y;
      sa_q[2] <= in_data_i.scale_z;
      sb_q    <= sa_q;
    end
  end

  // Quaternion products, then the nine rotation numerators and the norm.
  ptrs_numer u_numer (
    .clk_i  (clk_i),
    .en_i   (adv),
    .qx_i   (in_data_i.quat_x),
    .qy_i   (in_data_i.quat_y),
    .qz_i   (in_data_i.quat_z),
    .qw_i   (in_data_i.quat_w),
    .num_o  (num),
    .nrm_o  (nrm),
    .zero_o (zero)
  );

  // Lane index is column * 3 + row; column j takes scale j.
  for (genvar e = 0; e < 9; e++) begin : g_lane
    ptrs_lane #(
      .DIAG ((e % 4) == 0)
    ) u_lane (
      .clk_i  (clk_i),
      .en_i   (adv),
      .num_i  (num[e]),
      .s_i    (sb_q[e / 3]),
      .nrm_i  (nrm),
      .zero_i (zero),
      .res_o  (res[e])
    );
  end

  assign out_valid_o       = vld_q[LAT-1];
  assign out_data_o.col0_x = res[0];
  assign out_data_o.col0_y = res[1];
  assign out_data_o.col0_z = res[2];
  assign out_data_o.col1_x = res[3];
  assign out_data_o.col1_y = res[4];
  assign out_data_o.col1_z = res[5];
  assign out_data_o.col2_x = res[6];
  assign out_data_o.col2_y = res[7];
  assign out_data_o.col2_z = res[8];
  assign out_data_o.out_tx = tx_q[LAT-1];
  assign out_data_o.out_ty = ty_q[LAT-1];
  assign out_data_o.out_tz = tz_q[LAT-1];

endmodule

// ===== tb/sv/ptrs_checker.sv =====
// Checker for the pose to TRS matrix unit: watches both channels, predicts each
// output beat from the accepted input beat and compares field by field.
// Depends on ptrs_pkg for the beat structs.
`timescale 1ns / 1ps
module ptrs_checker (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                in_stall_i,
  input  ptrs_pkg::in_beat_t  in_data_i,
  input  logic                out_valid_i,
  input  logic                out_stall_i,
  input  ptrs_pkg::out_beat_t out_data_i,
  output int unsigned         fail_count_o,
  output int unsigned         pending_o
);
  import ptrs_pkg::*;

  out_beat_t matrix_q[$];

  // round(num * s / n), ties away from zero, saturated to 32 bits
  function automatic logic signed [31:0] scale_entry(longint num, longint s, longint n);
    logic neg;
    longint unsigned un, us, mag, q;
    neg = (num < 0) != (s < 0);
    un  = (num < 0) ? -num : num;
    us  = (s < 0) ? -s : s;
    mag = un * us;
    q   = (mag + (n >> 1)) / n;
    if (neg) begin
      if (q > 64'd2147483648) q = 64'd2147483648;
      return 32'(-longint'(q));
    end
    if (q > 64'd2147483647) q = 64'd2147483647;
    return 32'(q);
  endfunction

  function automatic out_beat_t compose_trs(in_beat_t b);
    out_beat_t r;
    longint x, y, z, w, n, sx, sy, sz;
    x = b.quat_x; y = b.quat_y; z = b.quat_z; w = b.quat_w;
    sx = b.scale_x; sy = b.scale_y; sz = b.scale_z;
    n = x*x + y*y + z*z + w*w;
    r = '0;
    if (n == 0) begin
      r.col0_x = b.scale_x; r.col1_y = b.scale_y; r.col2_z = b.scale_z;
    end else begin
      r.col0_x = scale_entry(n - 2*(y*y + z*z), sx, n);
      r.col0_y = scale_entry(2*(x*y + w*z), sx, n);
      r.col0_z = scale_entry(2*(x*z - w*y), sx, n);
      r.col1_x = scale_entry(2*(x*y - w*z), sy, n);
      r.col1_y = scale_entry(n - 2*(x*x + z*z), sy, n);
      r.col1_z = scale_entry(2*(y*z + w*x), sy, n);
      r.col2_x = scale_entry(2*(x*z + w*y), sz, n);
      r.col2_y = scale_entry(2*(y*z - w*x), sz, n);
      r.col2_z = scale_entry(n - 2*(x*x + y*y), sz, n);
    end
    r.out_tx = b.trans_x; r.out_ty = b.trans_y; r.out_tz = b.trans_z;
    return r;
  endfunction

  task automatic cmp(string name, logic [31:0] exp_v, logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected %0d actual %0d", name, $signed(exp_v), $signed(act_v));
      fail_count_o++;
    end
  endtask

  always @(posedge clk_i) begin
    out_beat_t e, a;
    if (rst_ni) begin
      if (in_valid_i && !in_stall_i) matrix_q.push_back(compose_trs(in_data_i));
      if (out_valid_i && !out_stall_i) begin
        a = out_data_i;
        if (matrix_q.size() == 0) begin
          $error("output beat with no expected matrix");
          fail_count_o++;
        end else begin
          e = matrix_q.pop_front();
          cmp("col0_x", e.col0_x, a.col0_x); cmp("col0_y", e.col0_y, a.col0_y);
          cmp("col0_z", e.col0_z, a.col0_z); cmp("col1_x", e.col1_x, a.col1_x);
          cmp("col1_y", e.col1_y, a.col1_y); cmp("col1_z", e.col1_z, a.col1_z);
          cmp("col2_x", e.col2_x, a.col2_x); cmp("col2_y", e.col2_y, a.col2_y);
          cmp("col2_z", e.col2_z, a.col2_z); cmp("out_tx", e.out_tx, a.out_tx);
          cmp("out_ty", e.out_ty, a.out_ty); cmp("out_tz", e.out_tz, a.out_tz);
        end
      end
      pending_o = matrix_q.size();
    end
  end
endmodule

// ===== tb/sv/tb_top.sv =====
// Top of the pose to TRS matrix testbench: clock, reset, stimulus and verdict.
// Depends on ptrs_pkg, pose_to_trs_matrix_unit and ptrs_checker.
`timescale 1ns / 1ps
module tb_top;
  import ptrs_pkg::*;

  localparam int N_RANDOM = 640;
  localparam int QUIET    = 120;   // last beats run with no idling

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  in_beat_t    in_data_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  out_beat_t   out_data_o;
  int unsigned fail_count, pending;
  bit          quiet = 1'b0;

  always #5 clk_i = ~clk_i;

  pose_to_trs_matrix_unit dut (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .in_data_i,
    .out_valid_o, .out_stall_i, .out_data_o
  );

  ptrs_checker u_checker (
    .clk_i, .rst_ni,
    .in_valid_i, .in_stall_i(in_stall_o), .in_data_i,
    .out_valid_i(out_valid_o), .out_stall_i, .out_data_i(out_data_o),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  // Receiver: stall in random bursts, none in the quiet tail.
  initial begin
    int k;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (!quiet && $urandom_range(0, 5) == 0) begin
        out_stall_i <= 1'b1;
        k = $urandom_range(1, 3);
        repeat (k - 1) @(posedge clk_i);
        @(posedge clk_i);
        out_stall_i <= 1'b0;
      end
    end
  end

  // Random field with frequent extremes.
  function automatic logic [31:0] pick32();
    case ($urandom_range(0, 7))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'h0001_0000;
      3: return 32'hffff_0000;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [15:0] pick16();
    case ($urandom_range(0, 7))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'h0000;
      3: return 16'h4000;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic in_beat_t pose_beat(logic [15:0] qx, logic [15:0] qy,
                                         logic [15:0] qz, logic [15:0] qw,
                                         logic [31:0] s);
    in_beat_t b;
    b.trans_x = $urandom; b.trans_y = $urandom; b.trans_z = $urandom;
    b.quat_x = qx; b.quat_y = qy; b.quat_z = qz; b.quat_w = qw;
    b.scale_x = s; b.scale_y = s; b.scale_z = s;
    return b;
  endfunction

  // Present one beat and hold it until accepted; outside the quiet tail an idle burst may precede it.
  task automatic send_pose(in_beat_t b);
    int k;
    if (!quiet && $urandom_range(0, 4) == 0) begin
      in_valid_i <= 1'b0;
      k = $urandom_range(1, 3);
      repeat (k) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= b;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
  endtask

  initial begin
    in_beat_t b;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: zero quaternion, identity, axis turns, non-unit, saturation.
    send_pose(pose_beat(16'h0000, 16'h0000, 16'h0000, 16'h0000, 32'h0001_0000));
    send_pose(pose_beat(16'h0000, 16'h0000, 16'h0000, 16'h0000, 32'h8000_0000));
    send_pose(pose_beat(16'h0000, 16'h0000, 16'h0000, 16'h4000, 32'h0001_0000));
    send_pose(pose_beat(16'h0000, 16'h0000, 16'h0000, 16'h0001, 32'h0002_8000));
    send_pose(pose_beat(16'h4000, 16'h0000, 16'h0000, 16'h0000, 32'h8000_0000));
    send_pose(pose_beat(16'h0000, 16'h4000, 16'h0000, 16'h0000, 32'h8000_0000));
    send_pose(pose_beat(16'h0000, 16'h0000, 16'h4000, 16'h0000, 32'h7fff_ffff));
    send_pose(pose_beat(16'h0000, 16'h0000, 16'h0000, 16'h8000, 32'h8000_0000));
    send_pose(pose_beat(16'h8000, 16'h8000, 16'h8000, 16'h8000, 32'h7fff_ffff));
    send_pose(pose_beat(16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 32'hffff_ffff));
    send_pose(pose_beat(16'h2d41, 16'h0000, 16'h0000, 16'h2d41, 32'h0001_0000));
    send_pose(pose_beat(16'h1000, 16'h2000, 16'h3000, 16'h4000, 32'h0003_0000));
    send_pose(pose_beat(16'h0001, 16'hffff, 16'h0001, 16'hffff, 32'h0000_0001));
    send_pose(pose_beat(16'h7fff, 16'h8000, 16'h0000, 16'h0001, 32'h0000_0000));
    b = pose_beat(16'h8000, 16'h0000, 16'h0000, 16'h0000, 32'h0);
    b.trans_x = 32'h8000_0000; b.trans_y = 32'h7fff_ffff; b.trans_z = 32'h0;
    b.scale_x = 32'h8000_0000; b.scale_y = 32'h7fff_ffff; b.scale_z = 32'h0;
    send_pose(b);

    // Hold off until the pipe has drained once.
    in_valid_i <= 1'b0;
    while (pending != 0) @(posedge clk_i);

    for (int i = 0; i < N_RANDOM; i++) begin
      if (i == N_RANDOM - QUIET) quiet = 1'b1;
      b = pose_beat(pick16(), pick16(), pick16(), pick16(), pick32());
      b.scale_y = pick32(); b.scale_z = pick32();
      b.trans_x = pick32(); b.trans_y = pick32(); b.trans_z = pick32();
      // Tiny quaternions stress the rounding with small norms.
      if ($urandom_range(0, 9) == 0) begin
        b.quat_x = 16'($signed(4'($urandom))); b.quat_y = 16'($signed(4'($urandom)));
        b.quat_z = 16'($signed(4'($urandom))); b.quat_w = 16'($signed(4'($urandom)));
      end
      send_pose(b);
    end
    in_valid_i <= 1'b0;

    while (pending != 0) @(posedge clk_i);
    repeat (LAT + 10) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("FAIL");
    $finish;
  end
endmodule
